// File: hw/rtl/lpmm_pkg.sv
// ----------------------------------------------------------------------------
// lpmm_pkg: shared types and codes for the loop profiler
// Opcode, status and result-kind codes plus the request and response beats.
// ----------------------------------------------------------------------------
package lpmm_pkg;

   localparam logic [2:0] OP_CLEAR     = 3'd0;
   localparam logic [2:0] OP_REGISTER  = 3'd1;
   localparam logic [2:0] OP_FSTART    = 3'd2;
   localparam logic [2:0] OP_FSTOP     = 3'd3;
   localparam logic [2:0] OP_LSTART    = 3'd4;
   localparam logic [2:0] OP_LSTOP     = 3'd5;
   localparam logic [2:0] OP_QLOOP     = 3'd6;
   localparam logic [2:0] OP_QFUNC     = 3'd7;

   localparam logic [2:0] ST_INIT      = 3'd0;
   localparam logic [2:0] ST_REG       = 3'd1;
   localparam logic [2:0] ST_STARTED   = 3'd2;
   localparam logic [2:0] ST_STOPPED   = 3'd3;
   localparam logic [2:0] ST_LSTARTED  = 3'd4;
   localparam logic [2:0] ST_LSTOPPED  = 3'd5;
   localparam logic [2:0] ST_ERROR     = 3'd6;

   localparam logic [2:0] KIND_STATUS  = 3'd0;
   localparam logic [2:0] KIND_HEADER  = 3'd1;
   localparam logic [2:0] KIND_MINENT  = 3'd2;
   localparam logic [2:0] KIND_MAXENT  = 3'd3;
   localparam logic [2:0] KIND_FSTATS  = 3'd4;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  func_id;
      logic [31:0] time_now;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  registered_count;
      logic [2:0]  item_kind;
      logic [7:0]  entry_id;
      logic [31:0] value_low;
      logic [31:0] value_high;
      logic [4:0]  run_length;
      logic        last;
   } rsp_type;

endpackage

// File: hw/rtl/lpmm_sub.sv
// ----------------------------------------------------------------------------
// lpmm_sub: shared duration unit
// One modular subtract and two unsigned compares, used by the function walk, loop fold and call sequence walk steps.
// ----------------------------------------------------------------------------
module lpmm_sub #(
   parameter int TIME_BITS = 32
) (
   input  logic [TIME_BITS-1:0] minuend,
   input  logic [TIME_BITS-1:0] subtrahend,
   input  logic [TIME_BITS-1:0] cur_min,
   input  logic [TIME_BITS-1:0] cur_max,
   output logic [TIME_BITS-1:0] diff,
   output logic                 below_min,
   output logic                 above_max
);
   // Differences wrap modulo the timer width.
   assign diff      = minuend - subtrahend;
   assign below_min = cur_min > diff;
   assign above_max = diff > cur_max;
endmodule

// File: hw/rtl/loop_profiler_minmax_monitor_top.sv
// ----------------------------------------------------------------------------
// loop_profiler_minmax_monitor_top: loop execution profiler
// Per-function and per-loop min/max durations with min/max call sequences.
// ----------------------------------------------------------------------------
// Usage: drive req_beat and raise start while busy is low; the event is taken
// on that edge. Every event answers with one or more response beats on
// rsp_beat, each marked by rsp_valid for exactly one cycle; the receiver
// cannot stall, and last marks the final beat of an event.
// Sequencing: register, function, loop-start and query-func events hold busy
// only through the response state and show their beat in the cycle after it;
// a new event is taken only once busy is low. Clear walks the tables one entry
// per cycle and holds busy until the last entry is done. Loop stop walks the
// function table, folds the loop time, walks the call sequence and then answers
// from the response state. A rejected loop stop answers from the function walk.
// Query loop gives one beat per cycle for 1+min_len+max_len beats and is busy
// while they go out. The final beat shows in the cycle busy falls.
// Reset (synchronous, active high) clears all profile state at once; the
// tables are flip-flop arrays, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module loop_profiler_minmax_monitor_top #(
   parameter int NUM_FUNCS = 16,
   parameter int TIME_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  lpmm_pkg::req_type  req_beat,
   output logic               rsp_valid,
   output lpmm_pkg::rsp_type  rsp_beat
);
   import lpmm_pkg::*;

   localparam int IW = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
   localparam int CW = $clog2(NUM_FUNCS + 1);
   localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};
   localparam logic [CW-1:0] NF = CW'(NUM_FUNCS);

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RESP  = 3'd1;
   localparam logic [2:0] S_FWALK = 3'd2;
   localparam logic [2:0] S_LOOP  = 3'd3;
   localparam logic [2:0] S_SWALK = 3'd4;
   localparam logic [2:0] S_QUERY = 3'd5;
   localparam logic [2:0] S_CLEAR = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [2:0] mode_ff, mode_in;
   logic [7:0] regs_ff, regs_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] ccnt_ff, ccnt_in;
   logic [CW-1:0] minlen_ff, minlen_in, maxlen_ff, maxlen_in;
   logic [TIME_BITS-1:0] lbeg_ff, lmin_ff, lmax_ff;
   logic newmin_ff, newmax_ff;
   req_type req_ff;
   rsp_type rsp_ff, rsp_in;
   logic rv_ff, rv_in;

   logic [7:0]           idtab_ff [NUM_FUNCS];
   logic [TIME_BITS-1:0] tstart_ff [NUM_FUNCS];
   logic [TIME_BITS-1:0] tstop_ff [NUM_FUNCS];
   logic [TIME_BITS-1:0] fmin_ff [NUM_FUNCS];
   logic [TIME_BITS-1:0] fmax_ff [NUM_FUNCS];
   logic [IW-1:0]        order_ff [NUM_FUNCS];
   logic [IW-1:0]        minid_ff [NUM_FUNCS];
   logic [TIME_BITS-1:0] mint_ff [NUM_FUNCS];
   logic [IW-1:0]        maxid_ff [NUM_FUNCS];
   logic [TIME_BITS-1:0] maxt_ff [NUM_FUNCS];

   logic id_ok;
   logic accept;
   logic [IW-1:0] rid, widx, sid;
   logic [TIME_BITS-1:0] tnow;
   logic [TIME_BITS-1:0] su_a, su_b, su_min, su_max, su_diff;
   logic su_lt, su_gt;
   logic [CW-1:0] qa;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);
   assign id_ok  = {3'b0, req_ff.func_id} < 11'(NUM_FUNCS);
   assign rid    = req_ff.func_id[IW-1:0];
   assign widx   = idx_ff[IW-1:0];
   assign sid    = order_ff[widx];
   // Timer sample fitted to the timer width.
   assign tnow   = TIME_BITS'(req_ff.time_now);

   // Shared duration unit operand selection.
   always_comb begin
      su_a = tstop_ff[widx];
      su_b = tstart_ff[widx];
      su_min = fmin_ff[widx];
      su_max = fmax_ff[widx];
      unique case (state_ff)
         S_LOOP: begin
            su_a = tnow;
            su_b = lbeg_ff;
            su_min = lmin_ff;
            su_max = lmax_ff;
         end
         S_SWALK: begin
            su_a = tstop_ff[sid];
            su_b = tstart_ff[sid];
         end
         default: ;
      endcase
   end

   lpmm_sub #(.TIME_BITS(TIME_BITS)) u_sub (
      .minuend(su_a), .subtrahend(su_b), .cur_min(su_min), .cur_max(su_max),
      .diff(su_diff), .below_min(su_lt), .above_max(su_gt)
   );

   function automatic logic [31:0] tw(input logic [TIME_BITS-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[31:0];
   endfunction

   // Sequencer control and response formation.
   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      regs_in = regs_ff;
      idx_in = idx_ff;
      ccnt_in = ccnt_ff;
      minlen_in = minlen_ff;
      maxlen_in = maxlen_ff;
      rv_in = 1'b0;
      rsp_in = '0;
      rsp_in.registered_count = regs_ff;
      rsp_in.status = mode_ff;
      rsp_in.last = 1'b1;
      qa = '0;
      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (accept) begin
               unique case (req_beat.opcode)
                  OP_CLEAR: state_in = S_CLEAR;
                  OP_LSTOP: state_in = S_FWALK;
                  OP_QLOOP: state_in = S_QUERY;
                  default:  state_in = S_RESP;
               endcase
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
            rv_in = 1'b1;
            unique case (req_ff.opcode)
               OP_REGISTER: begin
                  if (id_ok) begin
                     regs_in = regs_ff + 8'd1;
                     mode_in = ST_REG;
                  end else begin
                     mode_in = ST_ERROR;
                  end
               end
               OP_FSTART: if (mode_ff != ST_ERROR && id_ok) begin
                  if (ccnt_ff < NF) ccnt_in = ccnt_ff + CW'(1);
                  mode_in = ST_STARTED;
               end
               OP_FSTOP: if (mode_ff == ST_STARTED && id_ok) mode_in = ST_STOPPED;
               OP_LSTART: if (mode_ff != ST_ERROR) begin
                  ccnt_in = '0;
                  mode_in = ST_LSTARTED;
               end
               OP_LSTOP: mode_in = ST_LSTOPPED;
               OP_QFUNC: begin
                  if (id_ok) begin
                     rsp_in.item_kind = KIND_FSTATS;
                     rsp_in.entry_id = idtab_ff[rid];
                     rsp_in.value_low = tw(fmin_ff[rid]);
                     rsp_in.value_high = tw(fmax_ff[rid]);
                  end else begin
                     rsp_in.status = ST_ERROR;
                  end
               end
               default: ;
            endcase
            rsp_in.status = (req_ff.opcode == OP_QFUNC) ? rsp_in.status : mode_in;
            rsp_in.registered_count = regs_in;
         end
         S_CLEAR: begin
            idx_in = idx_ff + CW'(1);
            if (idx_ff == NF - CW'(1)) begin
               state_in = S_IDLE;
               rv_in = 1'b1;
               mode_in = ST_INIT;
               regs_in = '0;
               ccnt_in = '0;
               minlen_in = '0;
               maxlen_in = '0;
               rsp_in.status = ST_INIT;
               rsp_in.registered_count = '0;
            end
         end
         S_FWALK: begin
            if (mode_ff < ST_LSTARTED) begin
               state_in = S_IDLE;
               rv_in = 1'b1;
            end else begin
               idx_in = idx_ff + CW'(1);
               if (idx_ff == NF - CW'(1)) state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            idx_in = '0;
            state_in = S_SWALK;
         end
         S_SWALK: begin
            if (idx_ff >= ccnt_ff) begin
               if (newmin_ff) minlen_in = ccnt_ff;
               if (newmax_ff) maxlen_in = ccnt_ff;
               state_in = S_RESP;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         S_QUERY: begin
            rv_in = 1'b1;
            idx_in = idx_ff + CW'(1);
            if (idx_ff == '0) begin
               rsp_in.item_kind = KIND_HEADER;
               rsp_in.value_low = tw(lmin_ff);
               rsp_in.value_high = tw(lmax_ff);
               rsp_in.run_length = 5'(minlen_ff);
               rsp_in.last = (minlen_ff == '0) && (maxlen_ff == '0);
            end else if (idx_ff <= minlen_ff) begin
               qa = idx_ff - CW'(1);
               rsp_in.item_kind = KIND_MINENT;
               rsp_in.entry_id = 8'(minid_ff[qa[IW-1:0]]);
               rsp_in.value_low = tw(mint_ff[qa[IW-1:0]]);
               rsp_in.run_length = 5'(minlen_ff);
               rsp_in.last = (idx_ff == minlen_ff) && (maxlen_ff == '0);
            end else begin
               qa = idx_ff - minlen_ff - CW'(1);
               rsp_in.item_kind = KIND_MAXENT;
               rsp_in.entry_id = 8'(maxid_ff[qa[IW-1:0]]);
               rsp_in.value_low = tw(maxt_ff[qa[IW-1:0]]);
               rsp_in.run_length = 5'(maxlen_ff);
               rsp_in.last = (qa == maxlen_ff - CW'(1));
            end
            if (rsp_in.last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff <= ST_INIT;
         regs_ff <= '0;
         idx_ff <= '0;
         ccnt_ff <= '0;
         minlen_ff <= '0;
         maxlen_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         regs_ff <= regs_in;
         idx_ff <= idx_in;
         ccnt_ff <= ccnt_in;
         minlen_ff <= minlen_in;
         maxlen_ff <= maxlen_in;
         rv_ff <= rv_in;
      end
   end

   // Request and response beat registers.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) req_ff <= req_beat;
   end

   // Profile tables and loop statistics.
   always_ff @(posedge clock) begin
      if (reset) begin
         lbeg_ff <= '0;
         lmin_ff <= TMAX;
         lmax_ff <= '0;
         newmin_ff <= 1'b0;
         newmax_ff <= 1'b0;
         for (int i = 0; i < NUM_FUNCS; i++) begin
            idtab_ff[i] <= '0; tstart_ff[i] <= '0; tstop_ff[i] <= '0;
            fmin_ff[i] <= '0; fmax_ff[i] <= '0; order_ff[i] <= '0;
            minid_ff[i] <= '0; mint_ff[i] <= '0; maxid_ff[i] <= '0; maxt_ff[i] <= '0;
         end
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               // One entry of every cleared table per cycle.
               idtab_ff[widx] <= '0; fmin_ff[widx] <= '0; fmax_ff[widx] <= '0;
               order_ff[widx] <= '0; minid_ff[widx] <= '0; mint_ff[widx] <= '0;
               maxid_ff[widx] <= '0; maxt_ff[widx] <= '0;
               lmin_ff <= TMAX;
               lmax_ff <= '0;
            end
            S_RESP: begin
               unique case (req_ff.opcode)
                  OP_REGISTER: if (id_ok) begin
                     idtab_ff[rid] <= req_ff.func_id;
                     fmin_ff[rid] <= TMAX;
                     fmax_ff[rid] <= '0;
                  end
                  OP_FSTART: if (mode_ff != ST_ERROR && id_ok) begin
                     if (ccnt_ff < NF) order_ff[ccnt_ff[IW-1:0]] <= rid;
                     tstart_ff[rid] <= tnow;
                  end
                  OP_FSTOP: if (mode_ff == ST_STARTED && id_ok)
                     tstop_ff[rid] <= tnow;
                  OP_LSTART: if (mode_ff != ST_ERROR)
                     lbeg_ff <= tnow;
                  default: ;
               endcase
            end
            S_FWALK: if (mode_ff >= ST_LSTARTED) begin
               if (su_lt) fmin_ff[widx] <= su_diff;
               if (su_gt) fmax_ff[widx] <= su_diff;
            end
            S_LOOP: begin
               newmin_ff <= su_lt;
               newmax_ff <= su_gt;
               if (su_lt) lmin_ff <= su_diff;
               if (su_gt) lmax_ff <= su_diff;
            end
            S_SWALK: if (idx_ff < ccnt_ff) begin
               if (newmin_ff) begin
                  minid_ff[widx] <= sid;
                  mint_ff[widx] <= su_diff;
               end
               if (newmax_ff) begin
                  maxid_ff[widx] <= sid;
                  maxt_ff[widx] <= su_diff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_beat = rsp_ff;

endmodule

// File: hw/rtl/lpmm_checker.sv
// ----------------------------------------------------------------------------
// lpmm_checker: port-level checks for the loop profiler
// Watches the request and response ports and flags handshake slips.
// ----------------------------------------------------------------------------
module lpmm_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input lpmm_pkg::rsp_type rsp_beat
);
   import lpmm_pkg::*;

   // An accepted event always makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accept did not raise busy");

   // The block is already free in the cycle its final beat shows.
   a_last_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beat.last |-> !busy) else $error("busy after last beat");

   // Beats appear only while an event is in flight.
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> $past(busy)) else $error("stray beat");

   // Status never reports an undefined code.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_beat.status != 3'd7) else $error("bad status code");
endmodule

bind loop_profiler_minmax_monitor_top lpmm_checker u_lpmm_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_beat(rsp_beat)
);

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the loop profiler
// Drives profiler events from a queue, predicts every response beat in a
// software copy of the profile state, and checks beats in order as they come.
// ----------------------------------------------------------------------------
module tb;
   import lpmm_pkg::*;

   localparam int NF = 16;
   localparam int CYCLE_LIMIT = 400000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_beat;
   logic    rsp_valid;
   rsp_type rsp_beat;

   loop_profiler_minmax_monitor_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_beat(req_beat), .rsp_valid(rsp_valid), .rsp_beat(rsp_beat)
   );

   // Clock with a period of two units.
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Shadow copy of the profile state.
   logic [2:0]  pr_status;
   logic [7:0]  pr_regs;
   logic [7:0]  pr_ids [NF];
   logic [31:0] pr_t0 [NF];
   logic [31:0] pr_t1 [NF];
   logic [31:0] pr_fmin [NF];
   logic [31:0] pr_fmax [NF];
   logic [3:0]  pr_calls [NF];
   logic [4:0]  pr_ncalls;
   logic [31:0] pr_lbegin;
   logic [31:0] pr_lmin;
   logic [31:0] pr_lmax;
   logic [3:0]  pr_minids [NF];
   logic [31:0] pr_mintimes [NF];
   logic [4:0]  pr_minlen;
   logic [3:0]  pr_maxids [NF];
   logic [31:0] pr_maxtimes [NF];
   logic [4:0]  pr_maxlen;

   req_type pending_events[$];
   rsp_type expected_beats[$];
   int      send_idle_pct;
   int      mismatches;
   int      beats_seen;
   int      events_sent;
   int      cycle_count;

   // Return the profile to its cleared values; timestamps survive.
   function automatic void clear_profile();
      pr_status = ST_INIT;
      pr_regs   = '0;
      pr_ncalls = '0;
      pr_lmin   = '1;
      pr_lmax   = '0;
      pr_minlen = '0;
      pr_maxlen = '0;
      for (int i = 0; i < NF; i++) begin
         pr_ids[i] = '0;
         pr_fmin[i] = '0;
         pr_fmax[i] = '0;
         pr_calls[i] = '0;
         pr_minids[i] = '0;
         pr_mintimes[i] = '0;
         pr_maxids[i] = '0;
         pr_maxtimes[i] = '0;
      end
   endfunction

   function automatic void push_beat(logic [2:0] st, logic [2:0] kind, logic [7:0] id,
                                     logic [31:0] lo, logic [31:0] hi, logic [4:0] run,
                                     logic lst);
      rsp_type b;
      b.status = st;
      b.registered_count = pr_regs;
      b.item_kind = kind;
      b.entry_id = id;
      b.value_low = lo;
      b.value_high = hi;
      b.run_length = run;
      b.last = lst;
      expected_beats.push_back(b);
   endfunction

   // Fold the last call durations and the loop time into the min/max records.
   function automatic void close_loop(logic [31:0] now);
      logic [31:0] d;
      logic        new_min;
      logic        new_max;
      new_min = 1'b0;
      new_max = 1'b0;
      for (int i = 0; i < NF; i++) begin
         d = pr_t1[i] - pr_t0[i];
         if (pr_fmin[i] > d) pr_fmin[i] = d;
         if (d > pr_fmax[i]) pr_fmax[i] = d;
      end
      d = now - pr_lbegin;
      if (pr_lmin > d) begin
         pr_lmin = d;
         new_min = 1'b1;
      end
      if (d > pr_lmax) begin
         pr_lmax = d;
         new_max = 1'b1;
      end
      for (int i = 0; i < pr_ncalls; i++) begin
         if (new_max) begin
            pr_maxids[i] = pr_calls[i];
            pr_maxtimes[i] = pr_t1[pr_calls[i]] - pr_t0[pr_calls[i]];
         end
         if (new_min) begin
            pr_minids[i] = pr_calls[i];
            pr_mintimes[i] = pr_t1[pr_calls[i]] - pr_t0[pr_calls[i]];
         end
      end
      if (new_max) pr_maxlen = pr_ncalls;
      if (new_min) pr_minlen = pr_ncalls;
      pr_status = ST_LSTOPPED;
   endfunction

   // Advance the profile by one event and queue the beats it answers with.
   function automatic void profile_event(req_type ev);
      logic ok;
      ok = ev.func_id < NF;
      case (ev.opcode)
         OP_CLEAR: clear_profile();
         OP_REGISTER: begin
            if (ok) begin
               pr_regs++;
               pr_ids[ev.func_id] = ev.func_id;
               pr_fmin[ev.func_id] = '1;
               pr_fmax[ev.func_id] = '0;
               pr_status = ST_REG;
            end else begin
               pr_status = ST_ERROR;
            end
         end
         OP_FSTART: begin
            if (pr_status != ST_ERROR && ok) begin
               if (pr_ncalls < NF) begin
                  pr_calls[pr_ncalls] = ev.func_id[3:0];
                  pr_ncalls++;
               end
               pr_t0[ev.func_id] = ev.time_now;
               pr_status = ST_STARTED;
            end
         end
         OP_FSTOP: begin
            if (pr_status == ST_STARTED && ok) begin
               pr_t1[ev.func_id] = ev.time_now;
               pr_status = ST_STOPPED;
            end
         end
         OP_LSTART: begin
            if (pr_status != ST_ERROR) begin
               pr_ncalls = '0;
               pr_lbegin = ev.time_now;
               pr_status = ST_LSTARTED;
            end
         end
         OP_LSTOP: begin
            if (pr_status >= ST_LSTARTED) close_loop(ev.time_now);
         end
         OP_QLOOP: begin
            push_beat(pr_status, KIND_HEADER, '0, pr_lmin, pr_lmax, pr_minlen,
                      pr_minlen == 0 && pr_maxlen == 0);
            for (int i = 0; i < pr_minlen; i++)
               push_beat(pr_status, KIND_MINENT, pr_minids[i], pr_mintimes[i], '0,
                         pr_minlen, i + 1 == pr_minlen && pr_maxlen == 0);
            for (int i = 0; i < pr_maxlen; i++)
               push_beat(pr_status, KIND_MAXENT, pr_maxids[i], pr_maxtimes[i], '0,
                         pr_maxlen, i + 1 == pr_maxlen);
            return;
         end
         default: begin
            if (ok)
               push_beat(pr_status, KIND_FSTATS, pr_ids[ev.func_id], pr_fmin[ev.func_id],
                         pr_fmax[ev.func_id], '0, 1'b1);
            else
               push_beat(ST_ERROR, KIND_STATUS, '0, '0, '0, '0, 1'b1);
            return;
         end
      endcase
      push_beat(pr_status, KIND_STATUS, '0, '0, '0, '0, 1'b1);
   endfunction

   function automatic void add_event(logic [2:0] op, logic [7:0] id, logic [31:0] t);
      req_type ev;
      ev.opcode = op;
      ev.func_id = id;
      ev.time_now = t;
      pending_events.push_back(ev);
   endfunction

   function automatic logic [7:0] pick_id();
      return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(NF, 255))
                                         : 8'($urandom_range(0, NF - 1));
   endfunction

   // One well-formed loop with random calls and timestamps.
   function automatic void add_loop(inout logic [31:0] t);
      int n;
      logic [7:0] id;
      n = $urandom_range(0, 5);
      if ($urandom_range(0, 15) == 0) n = 18;
      t += $urandom_range(1, 50);
      add_event(OP_LSTART, '0, t);
      for (int i = 0; i < n; i++) begin
         id = pick_id();
         t += $urandom_range(0, 300);
         add_event(OP_FSTART, id, t);
         t += $urandom_range(0, 300);
         add_event(OP_FSTOP, id, t);
      end
      t += ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 500);
      add_event(OP_LSTOP, '0, t);
   endfunction

   // Driver: takes the next event when the block is free and the gap roll allows.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && !busy) && start) begin
         // Held event still waiting for the block.
      end else begin
         if (pending_events.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_beat <= pending_events.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Predict at acceptance, in event order.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         profile_event(req_beat);
         events_sent++;
      end
   end

   // Monitor: every strobed beat must match the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      cycle_count++;
      if (!reset && rsp_valid) begin
         beats_seen++;
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %p", rsp_beat);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_beat !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("beat %0d: expected %p, got %p", beats_seen, want, rsp_beat);
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Stimulus: directed events first, then three phases of random events and loops.
   initial begin
      logic [31:0] t;
      int k;
      reset = 1'b1;
      start = 1'b0;
      req_beat = '0;
      send_idle_pct = 13;
      mismatches = 0;
      beats_seen = 0;
      events_sent = 0;
      cycle_count = 0;
      for (int i = 0; i < NF; i++) begin
         pr_t0[i] = '0;
         pr_t1[i] = '0;
      end
      pr_lbegin = '0;
      clear_profile();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: queries on a fresh profile, extremes, rejected and error cases.
      add_event(OP_QLOOP, '0, '0);
      add_event(OP_QFUNC, 8'd255, '1);
      add_event(OP_FSTOP, 8'd3, 32'd5);
      add_event(OP_LSTOP, '0, 32'd9);
      add_event(OP_REGISTER, 8'd0, '0);
      add_event(OP_REGISTER, 8'd15, '0);
      add_event(OP_LSTART, '0, 32'hFFFF_FFF0);
      add_event(OP_FSTART, 8'd15, 32'hFFFF_FFFF);
      add_event(OP_FSTOP, 8'd15, 32'h0000_0010);
      add_event(OP_FSTART, 8'd200, 32'd1);
      add_event(OP_FSTART, 8'd0, 32'h20);
      add_event(OP_FSTOP, 8'd0, 32'h25);
      add_event(OP_LSTOP, '0, 32'h0000_0040);
      add_event(OP_QLOOP, '0, '0);
      add_event(OP_QFUNC, 8'd15, '0);
      add_event(OP_REGISTER, 8'd16, '0);
      add_event(OP_FSTART, 8'd1, 32'd7);
      add_event(OP_LSTART, '0, 32'd7);
      add_event(OP_LSTOP, '0, 32'hAAAA_5555);
      add_event(OP_QLOOP, '0, '0);
      add_event(OP_CLEAR, '0, '0);
      add_event(OP_QFUNC, 8'd0, '0);
      add_event(OP_QLOOP, '0, '0);

      t = $urandom;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 58 : 0;
         k = 0;
         while (k < 56) begin
            case ($urandom_range(0, 9))
               0: add_event(OP_REGISTER, pick_id(), $urandom);
               1: add_event(OP_QLOOP, '0, $urandom);
               2: add_event(OP_QFUNC, pick_id(), $urandom);
               3: add_event(3'($urandom_range(0, 7)), 8'($urandom), $urandom);
               default: begin
                  if ($urandom_range(0, 30) == 0) add_event(OP_CLEAR, '0, '0);
                  add_loop(t);
               end
            endcase
            k = k + 1 + 2 * $urandom_range(0, 3);
         end
         add_event(OP_QLOOP, '0, '0);
         while (pending_events.size() > 0 || expected_beats.size() > 0)
            @(posedge clock);
      end

      repeat (60) @(posedge clock);
      $display("covered %0d events and %0d response beats over %0d cycles",
               events_sent, beats_seen, cycle_count);
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d beats never seen", mismatches, expected_beats.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/lpmm_pkg.sv
hw/rtl/lpmm_sub.sv
hw/rtl/loop_profiler_minmax_monitor_top.sv
hw/rtl/lpmm_checker.sv
sim/tb.sv
